// ===== sv/tked_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tked_pkg;

    localparam int PARAM_BUF_DEPTH_DEF = 4;
    localparam int Q_DEPTH             = 4;
    localparam int Q_PTR_W             = $clog2(Q_DEPTH);
    localparam int Q_CNT_W             = $clog2(Q_DEPTH + 1);

    localparam logic [7:0]  ESC_BYTE      = 8'h1b;
    localparam logic [7:0]  CSI_BYTE      = 8'h5b;
    localparam logic [7:0]  SS3_BYTE      = 8'h4f;
    localparam logic [7:0]  TILDE_BYTE    = 8'h7e;
    localparam logic [7:0]  SEMI_BYTE     = 8'h3b;
    localparam logic [7:0]  NOMATCH       = 8'hff;
    localparam logic [7:0]  KEY_ESCAPE    = 8'd0;
    localparam logic [15:0] ESC_TICKS_RST = 16'd200;

    localparam logic CFG_BINARY_MODE = 1'b0;
    localparam logic CFG_ESC_TICKS   = 1'b1;

    typedef enum logic [2:0] {
        ST_NORMAL    = 3'd0,
        ST_AFTER_ESC = 3'd1,
        ST_AFTER_CSI = 3'd2,
        ST_AFTER_SS3 = 3'd3,
        ST_PARAMS    = 3'd4
    } t_state;

    // one queue entry: one or two key words from one input word
    typedef struct packed {
        logic       two;
        logic       sp0;
        logic [7:0] code0;
        logic [7:0] code1;
    } t_entry;

    typedef struct packed {
        logic push;
        logic full;
    } t_q_ctl;

    function automatic logic [7:0] csi_key(input logic [7:0] c);
        logic [7:0] k;
        case (c)
            8'h41:   k = 8'd1;
            8'h42:   k = 8'd2;
            8'h43:   k = 8'd3;
            8'h44:   k = 8'd4;
            8'h48:   k = 8'd5;
            8'h4b:   k = 8'd6;
            default: k = NOMATCH;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] ss3_key(input logic [7:0] c);
        logic [7:0] k;
        k = NOMATCH;
        if (c inside {[8'h50:8'h53]}) begin
            k = 8'd11 + (c - 8'h50);
        end
        return k;
    endfunction

    function automatic logic [7:0] param_key(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] k;
        k = NOMATCH;
        if (b == 8'h00) begin
            case (a)
                8'h31:   k = 8'd5;
                8'h34:   k = 8'd6;
                8'h35:   k = 8'd7;
                8'h36:   k = 8'd8;
                8'h32:   k = 8'd9;
                8'h33:   k = 8'd10;
                default: k = NOMATCH;
            endcase
        end else if (a == 8'h31) begin
            case (b)
                8'h31:   k = 8'd11;
                8'h32:   k = 8'd12;
                8'h33:   k = 8'd13;
                8'h34:   k = 8'd14;
                8'h35:   k = 8'd15;
                8'h37:   k = 8'd16;
                8'h38:   k = 8'd17;
                8'h39:   k = 8'd18;
                default: k = NOMATCH;
            endcase
        end else if (a == 8'h32) begin
            case (b)
                8'h30:   k = 8'd19;
                8'h31:   k = 8'd20;
                8'h33:   k = 8'd21;
                8'h34:   k = 8'd22;
                default: k = NOMATCH;
            endcase
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== sv/tked_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tked_front import tked_pkg::*; #(
    parameter int PARAM_BUF_DEPTH = PARAM_BUF_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_mode,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_clear,
    input  wire logic        i_binary_mode,
    input  wire logic [15:0] i_esc_ticks,
    input  wire logic        i_q_full,
    output t_q_ctl           o_q_ctl,
    output t_entry           o_entry
);

    localparam int PLW = $clog2(PARAM_BUF_DEPTH + 1);

    t_state         r_state, n_state;
    logic [7:0]     r_first, n_first;
    logic [7:0]     r_second, n_second;
    logic [PLW-1:0] r_len, n_len;
    logic [15:0]    r_timer, n_timer;
    logic           acc;
    logic           push;
    logic [7:0]     key;
    t_entry         entry;

    assign o_ready = !i_q_full;
    assign acc     = i_valid && !i_q_full;

    always_comb begin
        n_state  = r_state;
        n_first  = r_first;
        n_second = r_second;
        n_len    = r_len;
        n_timer  = r_timer;
        push     = 1'b0;
        key      = NOMATCH;
        entry    = '0;
        if (acc) begin
            if (i_mode) begin
                if (r_timer != 16'd0) begin
                    n_timer = r_timer - 16'd1;
                    if (r_timer == 16'd1 && r_state == ST_AFTER_ESC) begin
                        n_state     = ST_NORMAL;
                        push        = 1'b1;
                        entry.sp0   = 1'b1;
                        entry.code0 = KEY_ESCAPE;
                    end
                end
            end else begin
                n_timer = 16'd0;
                if (i_binary_mode) begin
                    push        = 1'b1;
                    entry.code0 = i_data_byte;
                end else begin
                    case (r_state)
                        ST_NORMAL: begin
                            if (i_data_byte == ESC_BYTE) begin
                                n_state = ST_AFTER_ESC;
                                n_timer = (i_esc_ticks != 16'd0) ? i_esc_ticks : 16'd1;
                            end else begin
                                push        = 1'b1;
                                entry.code0 = i_data_byte;
                            end
                        end
                        ST_AFTER_ESC: begin
                            if (i_data_byte == CSI_BYTE) begin
                                n_state = ST_AFTER_CSI;
                            end else if (i_data_byte == SS3_BYTE) begin
                                n_state = ST_AFTER_SS3;
                            end else begin
                                n_state     = ST_NORMAL;
                                push        = 1'b1;
                                entry.two   = 1'b1;
                                entry.sp0   = 1'b1;
                                entry.code0 = KEY_ESCAPE;
                                entry.code1 = i_data_byte;
                            end
                        end
                        ST_AFTER_CSI: begin
                            if (i_data_byte inside {[8'h30:8'h39]}) begin
                                n_state  = ST_PARAMS;
                                n_first  = i_data_byte;
                                n_second = 8'h00;
                                n_len    = PLW'(1);
                            end else begin
                                n_state = ST_NORMAL;
                                key     = csi_key(i_data_byte);
                            end
                        end
                        ST_AFTER_SS3: begin
                            n_state = ST_NORMAL;
                            key     = ss3_key(i_data_byte);
                        end
                        ST_PARAMS: begin
                            if (r_len < PLW'(PARAM_BUF_DEPTH) &&
                                (i_data_byte inside {[8'h30:8'h39]} ||
                                 i_data_byte == SEMI_BYTE)) begin
                                if (r_len == PLW'(1)) begin
                                    n_second = i_data_byte;
                                end
                                n_len = r_len + PLW'(1);
                            end else begin
                                n_state = ST_NORMAL;
                                if (i_data_byte == TILDE_BYTE) begin
                                    key = param_key(r_first, r_second);
                                end else begin
                                    push        = 1'b1;
                                    entry.code0 = i_data_byte;
                                end
                            end
                        end
                        default: begin
                            n_state  = ST_NORMAL;
                            n_first  = 8'h00;
                            n_second = 8'h00;
                            n_len    = '0;
                            n_timer  = 16'd0;
                        end
                    endcase
                    if (key != NOMATCH) begin
                        push        = 1'b1;
                        entry.sp0   = 1'b1;
                        entry.code0 = key;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_state  <= ST_NORMAL;
            r_first  <= 8'h00;
            r_second <= 8'h00;
            r_len    <= '0;
            r_timer  <= 16'd0;
        end else begin
            r_state  <= n_state;
            r_first  <= n_first;
            r_second <= n_second;
            r_len    <= n_len;
            r_timer  <= n_timer;
        end
    end

    assign o_q_ctl.push = push;
    assign o_q_ctl.full = i_q_full;
    assign o_entry      = entry;

endmodule

`default_nettype wire

// ===== sv/tked_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tked_queue import tked_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_q_ctl i_ctl,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_entry      o_head
);

    t_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               wr, rd;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr      = i_ctl.push && !i_ctl.full;
    assign rd      = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (wr && !rd) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (rd && !wr) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/tked_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tked_back import tked_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_empty,
    input  wire t_entry i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_ready,
    output logic        o_is_special,
    output logic [7:0]  o_key_code,
    output logic        o_last
);

    logic       r_valid;
    logic       r_half;
    logic       r_sp;
    logic [7:0] r_code;
    logic       r_last;
    logic       load;
    logic       first_of_two;

    assign load         = (!r_valid || i_ready) && !i_empty;
    assign first_of_two = i_head.two && !r_half;
    assign o_pop        = load && !first_of_two;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_half  <= first_of_two;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sp   <= r_half ? 1'b0 : i_head.sp0;
            r_code <= r_half ? i_head.code1 : i_head.code0;
            r_last <= !first_of_two;
        end
    end

    assign o_valid      = r_valid;
    assign o_is_special = r_sp;
    assign o_key_code   = r_code;
    assign o_last       = r_last;

endmodule

`default_nettype wire

// ===== sv/terminal_key_escape_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Terminal key decoder: turns received bytes and timer ticks (i_mode = 1) into
// key words, a character or a special key number. One input word is taken every
// cycle while the four-entry queue between parser and output stage has room; a
// word that gives Escape plus a character leaves one queue entry that the output
// register hands on as two key words, Escape first. A key word passes from the
// queue to the output register before it appears. Configuration writes are always
// taken; writing binary_mode also resets the parser and stops the escape timer.

module terminal_key_escape_decoder_core import tked_pkg::*; #(
    parameter int PARAM_BUF_DEPTH = PARAM_BUF_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_mode,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_is_special,
    output logic [7:0]       o_key_code,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic        r_binary_mode;
    logic [15:0] r_esc_ticks;
    logic        cfg_wr;
    logic        clear;
    logic        q_full, q_empty, q_pop;
    t_q_ctl      q_ctl;
    t_entry      f_entry, q_head;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign clear       = cfg_wr && (i_cfg_index == CFG_BINARY_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_binary_mode <= 1'b0;
            r_esc_ticks   <= ESC_TICKS_RST;
        end else if (cfg_wr) begin
            if (i_cfg_index == CFG_BINARY_MODE) begin
                r_binary_mode <= i_cfg_data[0];
            end else if (i_cfg_index == CFG_ESC_TICKS) begin
                r_esc_ticks <= i_cfg_data;
            end
        end
    end

    tked_front #(
        .PARAM_BUF_DEPTH(PARAM_BUF_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_mode       (i_mode),
        .i_data_byte  (i_data_byte),
        .i_clear      (clear),
        .i_binary_mode(r_binary_mode),
        .i_esc_ticks  (r_esc_ticks),
        .i_q_full     (q_full),
        .o_q_ctl      (q_ctl),
        .o_entry      (f_entry)
    );

    tked_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (q_ctl),
        .i_entry(f_entry),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_head (q_head)
    );

    tked_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_is_special(o_is_special),
        .o_key_code  (o_key_code),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

// ===== sv/tked_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tked_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic       o_is_special,
    input wire logic [7:0] o_key_code,
    input wire logic       o_last
);

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("key word valid straight after reset");

    a_pair_starts_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_is_special && o_key_code == 8'd0)
        else $error("first word of a pair is not Escape");

    a_pair_ends_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last && i_out_ready |=> o_out_valid && o_last && !o_is_special)
        else $error("Escape not followed by its character");

    a_special_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_special |-> o_key_code <= 8'd22)
        else $error("special key number out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_key_code))
        else $error("stalled key word changed");

endmodule

bind terminal_key_escape_decoder_core tked_checker u_tked_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_is_special(o_is_special),
    .o_key_code  (o_key_code),
    .o_last      (o_last)
);

`default_nettype wire

// ===== tb/tb_terminal_key_escape_decoder_core.sv =====
`timescale 1ns / 1ps

module tb_terminal_key_escape_decoder_core;
    import tked_pkg::*;

    typedef enum logic [7:0] {
        K_ESCAPE = 8'd0,
        K_UP, K_DOWN, K_RIGHT, K_LEFT, K_HOME, K_END, K_PGUP, K_PGDN, K_INS, K_DEL,
        K_F1, K_F2, K_F3, K_F4, K_F5, K_F6, K_F7, K_F8, K_F9, K_F10, K_F11, K_F12,
        K_NONE = 8'hff
    } t_key_code;

    typedef struct packed {
        logic       tick;
        logic [7:0] data;
    } t_in_word;

    typedef struct packed {
        logic       special;
        logic [7:0] code;
        logic       lst;
    } t_key_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        i_mode = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = 16'h0000;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_is_special;
    logic [7:0]  o_key_code;
    logic        o_last;
    logic        o_cfg_ready;

    terminal_key_escape_decoder_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_is_special (o_is_special),
        .o_key_code   (o_key_code),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    t_in_word    pending[$];
    t_key_word   key_exp[$];

    // decoder state as the block should hold it
    t_state      prs_state = ST_NORMAL;
    logic [7:0]  prm_first = 8'h00;
    logic [7:0]  prm_second = 8'h00;
    logic [2:0]  prm_len = 3'd0;
    logic [15:0] esc_timer = 16'd0;
    logic        bin_mode = 1'b0;
    logic [15:0] esc_ticks = ESC_TICKS_RST;

    bit          in_busy = 1'b0;
    bit          in_fire = 1'b0;
    bit          in_calm = 1'b0;
    bit          out_calm = 1'b0;
    int          gap_left = 0;
    int          out_stall = 0;
    int          err_cnt = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          cfg_writes = 0;
    int          gen_words = 0;
    bit          cur_bin = 1'b0;
    logic [15:0] cur_ticks = ESC_TICKS_RST;

    function automatic t_key_code csi_lookup(logic [7:0] c);
        case (c)
            "A":     return K_UP;
            "B":     return K_DOWN;
            "C":     return K_RIGHT;
            "D":     return K_LEFT;
            "H":     return K_HOME;
            "K":     return K_END;
            default: return K_NONE;
        endcase
    endfunction

    function automatic t_key_code ss3_lookup(logic [7:0] c);
        case (c)
            "P":     return K_F1;
            "Q":     return K_F2;
            "R":     return K_F3;
            "S":     return K_F4;
            default: return K_NONE;
        endcase
    endfunction

    function automatic t_key_code param_lookup(logic [7:0] a, logic [7:0] b);
        case ({a, b})
            {"1", 8'h00}: return K_HOME;
            {"4", 8'h00}: return K_END;
            {"5", 8'h00}: return K_PGUP;
            {"6", 8'h00}: return K_PGDN;
            {"2", 8'h00}: return K_INS;
            {"3", 8'h00}: return K_DEL;
            "11":         return K_F1;
            "12":         return K_F2;
            "13":         return K_F3;
            "14":         return K_F4;
            "15":         return K_F5;
            "17":         return K_F6;
            "18":         return K_F7;
            "19":         return K_F8;
            "20":         return K_F9;
            "21":         return K_F10;
            "23":         return K_F11;
            "24":         return K_F12;
            default:      return K_NONE;
        endcase
    endfunction

    function automatic void push_key(logic sp, logic [7:0] code, logic lst);
        t_key_word w;
        w.special = sp;
        w.code    = code;
        w.lst     = lst;
        key_exp.push_back(w);
    endfunction

    function automatic void clear_decoder();
        prs_state  = ST_NORMAL;
        prm_first  = 8'h00;
        prm_second = 8'h00;
        prm_len    = 3'd0;
        esc_timer  = 16'd0;
    endfunction

    function automatic void decode_word(logic is_tick, logic [7:0] c);
        t_key_code k;
        bit        dig;
        k   = K_NONE;
        dig = (c >= "0") && (c <= "9");
        if (is_tick) begin
            if (esc_timer != 16'd0) begin
                esc_timer = esc_timer - 16'd1;
                if (esc_timer == 16'd0 && prs_state == ST_AFTER_ESC) begin
                    prs_state = ST_NORMAL;
                    push_key(1'b1, K_ESCAPE, 1'b1);
                end
            end
            return;
        end
        esc_timer = 16'd0;
        if (bin_mode) begin
            push_key(1'b0, c, 1'b1);
            return;
        end
        case (prs_state)
            ST_NORMAL: begin
                if (c == ESC_BYTE) begin
                    prs_state = ST_AFTER_ESC;
                    esc_timer = (esc_ticks == 16'd0) ? 16'd1 : esc_ticks;
                end else begin
                    push_key(1'b0, c, 1'b1);
                end
            end
            ST_AFTER_ESC: begin
                if (c == CSI_BYTE) begin
                    prs_state = ST_AFTER_CSI;
                end else if (c == SS3_BYTE) begin
                    prs_state = ST_AFTER_SS3;
                end else begin
                    prs_state = ST_NORMAL;
                    push_key(1'b1, K_ESCAPE, 1'b0);
                    push_key(1'b0, c, 1'b1);
                end
            end
            ST_AFTER_CSI: begin
                if (dig) begin
                    prs_state  = ST_PARAMS;
                    prm_first  = c;
                    prm_second = 8'h00;
                    prm_len    = 3'd1;
                end else begin
                    prs_state = ST_NORMAL;
                    k = csi_lookup(c);
                end
            end
            ST_AFTER_SS3: begin
                prs_state = ST_NORMAL;
                k = ss3_lookup(c);
            end
            ST_PARAMS: begin
                if (prm_len < PARAM_BUF_DEPTH_DEF && (dig || c == SEMI_BYTE)) begin
                    if (prm_len == 3'd1)
                        prm_second = c;
                    prm_len = prm_len + 3'd1;
                end else begin
                    prs_state = ST_NORMAL;
                    if (c == TILDE_BYTE)
                        k = param_lookup(prm_first, (prm_len >= 3'd2) ? prm_second : 8'h00);
                    else
                        push_key(1'b0, c, 1'b1);
                end
            end
            default: clear_decoder();
        endcase
        if (k != K_NONE)
            push_key(1'b1, k, 1'b1);
    endfunction

    function automatic void apply_cfg(logic idx, logic [15:0] d);
        if (idx == CFG_BINARY_MODE) begin
            bin_mode = d[0];
            clear_decoder();
        end else begin
            esc_ticks = d;
        end
    endfunction

    function automatic void flag_mismatch(string what);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%0t ns mismatch: %s", $time, what);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // word driver
    always @(negedge i_clk) begin : word_drv
        t_in_word nxt;
        if (in_fire) begin
            in_fire  = 1'b0;
            in_busy  = 1'b0;
            gap_left = in_calm ? 0 : pick_gap();
        end
        if (i_rst_n && !in_busy) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending.size() != 0) begin
                nxt = pending.pop_front();
                i_mode      <= nxt.tick;
                i_data_byte <= nxt.data;
                i_in_valid  <= 1'b1;
                in_busy = 1'b1;
                if ($urandom_range(0, 199) == 0)
                    in_calm = !in_calm;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : word_take
        if (i_rst_n && i_in_valid && o_in_ready) begin
            decode_word(i_mode, i_data_byte);
            words_in++;
            in_fire = 1'b1;
        end
    end

    always @(negedge i_clk) begin : key_stall
        if (out_stall > 0) begin
            out_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!out_calm && $urandom_range(0, 3) == 0)
                out_stall = pick_gap();
        end
        if ($urandom_range(0, 299) == 0)
            out_calm = !out_calm;
    end

    always @(posedge i_clk) begin : key_mon
        t_key_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            words_out++;
            if (key_exp.size() == 0) begin
                flag_mismatch($sformatf("unexpected key word sp=%0b code=%0d last=%0b",
                                        o_is_special, o_key_code, o_last));
            end else begin
                want = key_exp.pop_front();
                if (o_is_special !== want.special || o_key_code !== want.code ||
                    o_last !== want.lst)
                    flag_mismatch($sformatf(
                        "expected sp=%0b code=%0d last=%0b, got sp=%0b code=%0d last=%0b",
                        want.special, want.code, want.lst, o_is_special, o_key_code, o_last));
            end
        end
    end

    task automatic add_byte(logic [7:0] b);
        t_in_word w;
        w.tick = 1'b0;
        w.data = b;
        pending.push_back(w);
        gen_words++;
    endtask

    task automatic add_tick(bit counted);
        t_in_word w;
        w.tick = 1'b1;
        w.data = 8'($urandom_range(0, 255));
        pending.push_back(w);
        if (counted)
            gen_words++;
    endtask

    task automatic add_esc(string s);
        add_byte(ESC_BYTE);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    task automatic random_burst();
        string      csi_fin;
        int         r;
        int         n;
        int         eff;
        logic [7:0] b;
        csi_fin = "ABCDHK";
        eff = (cur_ticks == 16'd0) ? 1 : int'(cur_ticks);
        r = $urandom_range(0, 99);
        if (r < 14) begin
            add_byte(8'($urandom_range(0, 255)));
        end else if (r < 28) begin
            add_esc("[");
            if ($urandom_range(0, 3) != 0)
                add_byte(csi_fin[$urandom_range(0, 5)]);
            else
                add_byte(8'($urandom_range(0, 255)));
        end else if (r < 38) begin
            add_esc("O");
            if ($urandom_range(0, 3) != 0)
                add_byte(8'("P" + $urandom_range(0, 3)));
            else
                add_byte(8'($urandom_range(0, 255)));
        end else if (r < 63) begin
            add_esc("[");
            r = $urandom_range(0, 9);
            n = (r < 3) ? 1 : (r < 7) ? 2 : $urandom_range(3, 5);
            if ($urandom_range(0, 9) < 7)
                add_byte(8'("1" + $urandom_range(0, 5)));
            else
                add_byte(rand_digit());
            for (int i = 1; i < n; i++)
                add_byte(($urandom_range(0, 4) != 0) ? rand_digit() : SEMI_BYTE);
            r = $urandom_range(0, 9);
            if (r < 8)
                add_byte(TILDE_BYTE);
            else
                add_byte(8'($urandom_range(0, 255)));
        end else if (r < 72) begin
            add_esc("");
            add_byte(8'($urandom_range(0, 255)));
        end else if (r < 85) begin
            add_esc("");
            if (eff <= 20)
                n = $urandom_range(0, eff + 2);
            else if (eff <= 300 && $urandom_range(0, 15) == 0)
                n = eff;
            else
                n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
                add_tick(1'b1);
            if ($urandom_range(0, 1) == 0) begin
                b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255)) : CSI_BYTE;
                add_byte(b);
            end
        end else if (r < 90) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                add_tick(1'b0);
        end else begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                b = ($urandom_range(0, 3) == 0) ? ESC_BYTE : 8'($urandom_range(0, 255));
                add_byte(b);
            end
        end
    endtask

    task automatic gen_random(int words);
        int target;
        int eff;
        target = gen_words + words;
        eff = (cur_ticks == 16'd0) ? 1 : int'(cur_ticks);
        // lone escape run out to its timeout where that is short
        if (!cur_bin && eff <= 20) begin
            add_esc("");
            for (int i = 0; i < eff; i++)
                add_tick(1'b1);
        end
        while (gen_words < target)
            random_burst();
    endtask

    task automatic wait_quiet();
        while (pending.size() != 0 || in_busy || key_exp.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic idx, logic [15:0] d);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        apply_cfg(idx, d);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(bit wr_bin, bit bin, logic [15:0] ticks, int words);
        logic [15:0] d;
        wait_quiet();
        cfg_write(CFG_ESC_TICKS, ticks);
        if (wr_bin) begin
            d = 16'($urandom_range(0, 65535));
            d[0] = bin;
            cfg_write(CFG_BINARY_MODE, d);
            cur_bin = bin;
        end
        cur_ticks = ticks;
        gen_random(words);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_byte(8'h00);
        add_byte(8'hff);
        add_esc("[A");
        add_esc("OS");
        add_esc("[24~");
        add_esc("[3~");
        add_esc("[Z");
        add_esc("x");
        add_esc("[1q");
        add_tick(1'b0);
        gen_random(150);

        // tick register alone leaves a running countdown alone
        run_phase(1'b0, 1'b0, 16'd0, 200);
        run_phase(1'b1, 1'b0, 16'd1, 200);
        run_phase(1'b1, 1'b1, 16'hffff, 120);
        run_phase(1'b1, 1'b0, 16'd7, 250);
        run_phase(1'b1, 1'b0, 16'hffff, 150);
        run_phase(1'b0, 1'b0, 16'd3, 250);
        run_phase(1'b1, 1'b0, 16'($urandom_range(2, 15)), 200);
        run_phase(1'b1, 1'b1, 16'd1, 80);
        wait_quiet();

        if (key_exp.size() != 0) begin
            $display("%0d expected key words never arrived", key_exp.size());
            err_cnt += key_exp.size();
        end
        $display("Run covered %0d input words and %0d key words over %0d register writes",
                 words_in, words_out, cfg_writes);
        $display("Settings visited: binary and text mode, escape timeout 0, 1, 3, 7, 200, 65535");
        if (err_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
